[hdl/oaht_pkg.sv]
package oaht_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;
  localparam int FILL_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL      = 2'd2;

  localparam logic [1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [1:0] SLOT_DELETED  = 2'd1;
  localparam logic [1:0] SLOT_OCCUPIED = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

  localparam logic [MODE_W-1:0] PROBE_MODE_RST = MODE_LINEAR;
  localparam logic [FILL_W-1:0] FILL_LIMIT_RST = 5'd12;

  localparam logic [0:0] REG_PROBE_MODE = 1'b0;
  localparam logic [0:0] REG_FILL_LIMIT = 1'b1;

  localparam logic [3:0] DH_PRIME = 4'd7;

  typedef struct packed {
    logic [1:0]         st;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

[hdl/open_addressing_hash_table_unit.sv]
// Open-addressing key/value table of CAPACITY slots held in one synchronous memory.
// Each request (insert, delete or lookup) gives exactly one result. A request first
// reduces the key modulo CAPACITY by a reciprocal multiplication and modulo seven by
// folding three-bit digits, registering the product and then the quotient times CAPACITY,
// and then walks its probe sequence, where every probe is a read of the slot memory whose
// registered data is evaluated in the state after the read. A request makes 1 to CAPACITY
// probes, and an unused op code skips both and ends with not found.
// After reset the slot memory is swept once, one slot a cycle, before the first request
// is taken; configuration writes are taken at any time.
module open_addressing_hash_table_unit
  import oaht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [0:0]  cfg_addr,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // op [1:0], key [32:2], value [64:33], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status [1:0], found_value [33:2], zeros above
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int SW1 = ((AW > 3) ? AW : 3) + 1;
  localparam int RS  = KEY_W + AW;
  localparam int PW  = KEY_W + 32;
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [AW:0]   CAP_X    = (AW + 1)'(CAPACITY);
  localparam logic [SW1-1:0] CAP_S   = SW1'(CAPACITY);
  localparam logic [KEY_W-1:0] CAP_K = KEY_W'(CAPACITY);
  localparam logic [63:0] RECIP_W    = ((64'd1 << RS) + 64'(CAPACITY) - 64'd1) /
                                       64'(CAPACITY);
  localparam logic [31:0] RECIP      = 32'(RECIP_W);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_RD, S_EV, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        step_r, step_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [KEY_W-1:0]     qc_r, qc_nxt;
  logic [2:0]           rem_7_r, rem_7_nxt;
  logic [1:0]           mod_cnt_r, mod_cnt_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [FILL_W-1:0]    occ_r, occ_nxt;
  logic [MODE_W-1:0]    probe_mode_r;
  logic [FILL_W-1:0]    fill_limit_r;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]   res_found_r, res_found_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]   out_found_r, out_found_nxt;

  entry_t               mem [CAPACITY];
  entry_t               rd_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  entry_t               mem_wd;

  logic [32:0]          key_pad;
  logic [6:0]           f7_a;
  logic [3:0]           f7_b;
  logic [3:0]           f7_c;
  logic [2:0]           r7;
  logic [KEY_W-1:0]     quo;
  logic [KEY_W-1:0]     rem_k;
  logic [3:0]           dstep;
  logic [SW1-1:0]       ds;
  logic [AW:0]          pos_sum;
  logic [AW:0]          quad_sum;
  logic                 slot_occ;
  logic                 slot_match;

  // Eight is one modulo seven, so the three-bit digits of the key sum to the same remainder.
  always_comb begin
    key_pad = {2'b00, key_r};
    f7_a = '0;
    for (int j = 0; j < 11; j++) begin
      f7_a = f7_a + 7'(key_pad[3*j +: 3]);
    end
    f7_b = 4'(f7_a[2:0]) + 4'(f7_a[5:3]) + 4'(f7_a[6]);
    f7_c = 4'(f7_b[2:0]) + 4'(f7_b[3]);
    r7 = (f7_c >= DH_PRIME) ? 3'(f7_c - DH_PRIME) : f7_c[2:0];
    quo = KEY_W'(prod_r >> RS);
    rem_k = key_r - qc_r;
    dstep = DH_PRIME - {1'b0, rem_7_r};
    ds = SW1'(dstep);
    for (int j = 0; j < 3; j++) begin
      if (ds >= CAP_S) begin
        ds = ds - CAP_S;
      end
    end
  end

  always_comb begin
    pos_sum = {1'b0, pos_r} + {1'b0, step_r};
    if (pos_sum >= CAP_X) begin
      pos_sum = pos_sum - CAP_X;
    end
    quad_sum = {1'b0, step_r} + (AW + 1)'(2);
    if (quad_sum >= CAP_X) begin
      quad_sum = quad_sum - CAP_X;
    end
  end

  assign slot_occ   = (rd_q.st == SLOT_OCCUPIED);
  assign slot_match = slot_occ && (rd_q.key == key_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    prod_nxt       = prod_r;
    qc_nxt         = qc_r;
    rem_7_nxt      = rem_7_r;
    mod_cnt_nxt    = mod_cnt_r;
    mode_nxt       = mode_r;
    occ_nxt        = occ_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = rd_q;

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wa    = cnt_r;
        mem_wd    = '0;
        mem_wd.st = SLOT_EMPTY;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt        = in_tdata[1:0];
          key_nxt       = in_tdata[32:2];
          val_nxt       = in_tdata[64:33];
          mod_cnt_nxt   = '0;
          cnt_nxt       = '0;
          mode_nxt      = probe_mode_r;
          res_found_nxt = '0;
          if (in_tdata[1:0] == OP_INSERT || in_tdata[1:0] == OP_DELETE ||
              in_tdata[1:0] == OP_LOOKUP) begin
            state_nxt = S_MOD;
          end else begin
            res_status_nxt = RES_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end
      S_MOD: begin
        mod_cnt_nxt = mod_cnt_r + 2'd1;
        if (mod_cnt_r == 2'd0) begin
          prod_nxt  = PW'(key_r) * PW'(RECIP);
          rem_7_nxt = r7;
        end else if (mod_cnt_r == 2'd1) begin
          qc_nxt = quo * CAP_K;
        end else begin
          mod_cnt_nxt = '0;
          pos_nxt     = rem_k[AW-1:0];
          if (mode_r == MODE_DOUBLE) begin
            step_nxt = ds[AW-1:0];
          end else begin
            step_nxt = AW'(1);
          end
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (op_r == OP_INSERT) begin
          if (slot_match) begin
            mem_we         = 1'b1;
            mem_wd.value   = val_r;
            res_status_nxt = RES_OK;
            state_nxt      = S_DONE;
          end else if (!slot_occ) begin
            if (occ_r < fill_limit_r) begin
              mem_we         = 1'b1;
              mem_wd.st      = SLOT_OCCUPIED;
              mem_wd.key     = key_r;
              mem_wd.value   = val_r;
              occ_nxt        = occ_r + FILL_W'(1);
              res_status_nxt = RES_OK;
            end else begin
              res_status_nxt = RES_FULL;
            end
            state_nxt = S_DONE;
          end
        end else begin
          if (rd_q.st == SLOT_EMPTY) begin
            res_status_nxt = RES_NOT_FOUND;
            state_nxt      = S_DONE;
          end else if (slot_match) begin
            if (op_r == OP_DELETE) begin
              mem_we    = 1'b1;
              mem_wd.st = SLOT_DELETED;
              if (occ_r != '0) begin
                occ_nxt = occ_r - FILL_W'(1);
              end
            end else begin
              res_found_nxt = rd_q.value;
            end
            res_status_nxt = RES_OK;
            state_nxt      = S_DONE;
          end
        end
        if (state_nxt == S_EV) begin
          if (cnt_r == LAST_IDX) begin
            res_status_nxt = (op_r == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
            state_nxt      = S_DONE;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
            pos_nxt = pos_sum[AW-1:0];
            if (mode_r == MODE_QUADRATIC) begin
              step_nxt = quad_sum[AW-1:0];
            end
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      mod_cnt_r    <= '0;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
      probe_mode_r <= PROBE_MODE_RST;
      fill_limit_r <= FILL_LIMIT_RST;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      mod_cnt_r    <= mod_cnt_nxt;
      occ_r        <= occ_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_PROBE_MODE: probe_mode_r <= cfg_wdata[MODE_W-1:0];
          REG_FILL_LIMIT: fill_limit_r <= cfg_wdata[FILL_W-1:0];
          default: ;
        endcase
      end
    end
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    prod_r       <= prod_nxt;
    qc_r         <= qc_nxt;
    rem_7_r      <= rem_7_nxt;
    mode_r       <= mode_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[pos_r];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_found_r, out_status_r};

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= CAPACITY)
    else $error("occupied count exceeds capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != RES_OK) |-> (out_tdata[33:2] == '0))
    else $error("value returned with a failing status");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EV || state_r == S_CLR))
    else $error("slot memory written outside probe evaluation or clearing");
`endif

endmodule

[tb/open_addressing_hash_table_unit_tb.sv]
module open_addressing_hash_table_unit_tb;
  import oaht_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 250000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [0:0]  cfg_addr;
  logic [4:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // op [1:0], key [32:2], value [64:33], zeros above
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // status [1:0], found_value [33:2], zeros above

  // Shadow copy of the table and its registers.
  logic [KEY_W-1:0]    shadow_key [SLOTS];
  logic [VALUE_W-1:0]  shadow_value [SLOTS];
  logic [1:0]          shadow_state [SLOTS];
  int unsigned         shadow_count;
  logic [MODE_W-1:0]   shadow_mode;
  logic [FILL_W-1:0]   shadow_fill;

  table_result_t pending_results [$];
  int unsigned   cycle_count;
  int unsigned   fail_count;
  int unsigned   requests_sent;
  int unsigned   results_checked;
  int unsigned   status_seen [3];
  bit            gaps_on;
  bit            long_hold_req;

  open_addressing_hash_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned probe_slot(input logic [KEY_W-1:0] key,
                                             input int unsigned step);
    longint unsigned k;
    longint unsigned n;
    longint unsigned pos;
    k = key;
    n = step;
    case (shadow_mode)
      MODE_QUADRATIC: pos = k + n * n;
      MODE_DOUBLE:    pos = (k % SLOTS) + n * (DH_PRIME - (k % DH_PRIME));
      default:        pos = k + n;
    endcase
    return pos % SLOTS;
  endfunction

  function automatic table_result_t table_apply_request(input logic [OP_W-1:0] op,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [VALUE_W-1:0] value);
    table_result_t res;
    int unsigned s;
    bit done;
    res.status = RES_NOT_FOUND;
    res.found = '0;
    done = 1'b0;
    if (op == OP_INSERT) begin
      res.status = RES_FULL;
      for (int i = 0; i < SLOTS && !done; i++) begin
        s = probe_slot(key, i);
        if (shadow_state[s] == SLOT_OCCUPIED) begin
          if (shadow_key[s] == key) begin
            shadow_value[s] = value;
            res.status = RES_OK;
            done = 1'b1;
          end
        end else begin
          if (shadow_count < shadow_fill) begin
            shadow_key[s] = key;
            shadow_value[s] = value;
            shadow_state[s] = SLOT_OCCUPIED;
            shadow_count++;
            res.status = RES_OK;
          end
          done = 1'b1;
        end
      end
    end else if (op == OP_DELETE || op == OP_LOOKUP) begin
      for (int i = 0; i < SLOTS && !done; i++) begin
        s = probe_slot(key, i);
        if (shadow_state[s] == SLOT_EMPTY) begin
          done = 1'b1;
        end else if (shadow_state[s] == SLOT_OCCUPIED && shadow_key[s] == key) begin
          if (op == OP_DELETE) begin
            shadow_state[s] = SLOT_DELETED;
            if (shadow_count > 0) shadow_count--;
          end else begin
            res.found = shadow_value[s];
          end
          res.status = RES_OK;
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("MISMATCH cycle %0d: %s got 0x%08h expected 0x%08h", cycle_count, what,
             got_v, want_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    table_result_t got;
    table_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.found = out_tdata[33:2];
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with no request outstanding", got.status,
                          got.found);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.found != want.found)
            report_mismatch("found_value", got.found, want.found);
          if (want.status < 3) status_seen[want.status]++;
        end
        results_checked++;
      end
      if (cfg_wen) begin
        if (cfg_addr == REG_PROBE_MODE) shadow_mode = cfg_wdata[MODE_W-1:0];
        else shadow_fill = cfg_wdata[FILL_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(table_apply_request(in_tdata[1:0], in_tdata[32:2],
                                                      in_tdata[64:33]));
        requests_sent++;
      end
    end
  end

  initial begin : receiver
    int unsigned hold_count;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, value, key, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic reconfigure_table(input logic [MODE_W-1:0] mode,
                                   input logic [FILL_W-1:0] fill);
    wait_drained();
    write_reg(REG_PROBE_MODE, {3'b0, mode});
    write_reg(REG_FILL_LIMIT, fill);
  endtask

  task automatic run_request_mix(input int unsigned count);
    logic [KEY_W-1:0] pool [20];
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    int unsigned      r;
    foreach (pool[j]) pool[j] = (j < 10) ? KEY_W'($urandom_range(0, 63)) : KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      op = (r < 45) ? OP_INSERT : (r < 75) ? OP_LOOKUP : (r < 95) ? OP_DELETE : OP_UNUSED;
      key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : pool[$urandom_range(0, 19)];
      send_request(op, key, $urandom);
    end
  endtask

  task automatic test_directed_requests();
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 31'd16, 32'hA5A5_A5A5);
    send_request(OP_LOOKUP, 31'd16, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 31'h7FFF_FFFF, '0);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_INSERT, '0, 32'h5A5A_5A5A);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_DELETE, '0, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, 31'd16, '0);
    send_request(OP_INSERT, 31'd32, 32'h1234_5678);
    send_request(OP_DELETE, 31'd48, '0);
    send_request(OP_LOOKUP, 31'd5, '0);
    send_request(OP_UNUSED, 31'd16, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 31'd32, '0);
  endtask

  task automatic test_fill_limit_zero();
    reconfigure_table(MODE_LINEAR, 5'd0);
    send_request(OP_INSERT, 31'd7, 32'hDEAD_BEEF);
    send_request(OP_INSERT, 31'd16, 32'h0F0F_0F0F);
    send_request(OP_LOOKUP, 31'd7, '0);
  endtask

  task automatic test_linear_probing();
    reconfigure_table(MODE_LINEAR, 5'd16);
    run_request_mix(90);
  endtask

  task automatic test_quadratic_probing();
    reconfigure_table(MODE_QUADRATIC, 5'd31);
    run_request_mix(90);
  endtask

  task automatic test_output_backpressure();
    reconfigure_table(MODE_DOUBLE, 5'd12);
    long_hold_req = 1'b1;
    run_request_mix(40);
    wait_drained();
    run_request_mix(50);
  endtask

  task automatic test_unused_probe_mode();
    reconfigure_table(MODE_UNUSED, 5'd1);
    run_request_mix(40);
    reconfigure_table(MODE_DOUBLE, 5'd31);
    run_request_mix(60);
  endtask

  task automatic test_full_rate();
    gaps_on = 1'b0;
    reconfigure_table(MODE_QUADRATIC, 5'd8);
    run_request_mix(100);
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wen = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cycle_count = 0;
    fail_count = 0;
    requests_sent = 0;
    results_checked = 0;
    status_seen = '{0, 0, 0};
    gaps_on = 1'b1;
    long_hold_req = 1'b0;
    shadow_mode = PROBE_MODE_RST;
    shadow_fill = FILL_LIMIT_RST;
    shadow_count = 0;
    foreach (shadow_state[j]) shadow_state[j] = SLOT_EMPTY;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_requests();
    test_fill_limit_zero();
    test_linear_probing();
    test_quadratic_probing();
    test_output_backpressure();
    test_unused_probe_mode();
    test_full_rate();

    repeat (60) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("requests left without a result", pending_results.size(), 0);
    $display("Checked %0d results for %0d requests over all four probe modes", results_checked,
             requests_sent);
    $display("Outcomes: %0d done or found, %0d not found, %0d full", status_seen[0],
             status_seen[1], status_seen[2]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
